@@ rtl/nv21_pkg.sv @@
package nv21_pkg;

    // Build-time defaults for the frame geometry limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register widths and reset values
    localparam int HALF_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam logic [HALF_WIDTH_W-1:0]   HALF_WIDTH_RST   = 11'd320;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_HALF_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Conversion constants
    localparam logic [7:0]         LUMA_OFFSET   = 8'd16;
    localparam logic [7:0]         CHROMA_OFFSET = 8'd128;
    localparam logic [10:0]        COEF_Y        = 11'd1192;
    localparam logic signed [12:0] COEF_RV       = 13'sd1634;
    localparam logic signed [12:0] COEF_GV       = 13'sd833;
    localparam logic signed [12:0] COEF_GU       = 13'sd400;
    localparam logic signed [12:0] COEF_BU       = 13'sd2066;
    localparam logic [17:0]        CHAN_MAX      = 18'd262143;
    localparam logic [7:0]         ALPHA_OPAQUE  = 8'hff;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cr_sample;
        logic [7:0] cb_sample;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] argb_word;
        logic        line_end;
        logic        frame_end;
    } pix_out_t;

    typedef struct packed {
        logic [HALF_WIDTH_W-1:0]   half_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] cr;
        logic [7:0] cb;
    } chroma_t;

    // One classified pixel handed from the front end to the math pipeline
    typedef struct packed {
        logic [7:0] luma;
        chroma_t    chroma;
        logic       line_end;
        logic       frame_end;
    } work_t;

    typedef enum logic [1:0] {
        SRC_INPUT = 2'd0,
        SRC_LINE  = 2'd1,
        SRC_HELD  = 2'd2
    } chroma_src_t;

endpackage

@@ rtl/nv21_ram.sv @@
module nv21_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nv21_front.sv @@
module nv21_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  nv21_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  nv21_pkg::pix_in_t s_data,
    output logic             wk_valid,
    input  logic             wk_ready,
    output nv21_pkg::work_t  wk_data
);

    import nv21_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int HW_X       = ((COL_W > HALF_WIDTH_W) ? COL_W : HALF_WIDTH_W) + 2;
    localparam int FH_X       = ((ROW_W + 1 > FRAME_HEIGHT_W) ? ROW_W + 1 : FRAME_HEIGHT_W) + 1;

    typedef struct packed {
        logic [7:0]  luma;
        chroma_t     in_chroma;
        chroma_src_t src;
        logic        line_end;
        logic        frame_end;
    } front_t;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             f_valid_reg, f_valid_next;
    front_t           f_item_reg, f_item_next;
    chroma_t          held_chroma_reg, held_chroma_next;

    logic [HW_X-1:0]  hw_x, hw_eff, last_col;
    logic [FH_X-1:0]  fh_x, fh_eff, last_row;
    logic             line_end, frame_end;
    logic             accept, move;
    chroma_src_t      src;
    logic [SLOT_W-1:0] slot;
    logic             ram_we, ram_re;
    logic [15:0]      ram_rdata;
    chroma_t          resolved;

    // Clamp the geometry registers to the supported range
    always_comb begin
        hw_x = HW_X'(cfg.half_width);
        if (hw_x == '0) begin
            hw_eff = HW_X'(1);
        end else if (hw_x > HW_X'(LINE_DEPTH)) begin
            hw_eff = HW_X'(LINE_DEPTH);
        end else begin
            hw_eff = hw_x;
        end
        last_col = (hw_eff << 1) - HW_X'(1);

        fh_x = FH_X'(cfg.frame_height);
        if (fh_x == '0) begin
            fh_eff = FH_X'(1);
        end else if (fh_x > FH_X'(MAX_HEIGHT)) begin
            fh_eff = FH_X'(MAX_HEIGHT);
        end else begin
            fh_eff = fh_x;
        end
        last_row = fh_eff - FH_X'(1);
    end

    assign line_end  = HW_X'(col_reg) >= last_col;
    assign frame_end = line_end && (FH_X'(row_reg) >= last_row);

    assign move    = f_valid_reg && wk_ready;
    assign s_ready = !f_valid_reg || wk_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (col_reg[0]) begin
            src = SRC_HELD;
        end else if (!row_reg[0]) begin
            src = SRC_INPUT;
        end else begin
            src = SRC_LINE;
        end
    end

    assign slot   = SLOT_W'(col_reg >> 1);
    assign ram_we = accept && (src == SRC_INPUT);
    assign ram_re = accept && (src == SRC_LINE);

    nv21_ram #(
        .WIDTH (16),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata ({s_data.cr_sample, s_data.cb_sample}),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // The line store read lands together with the registered item
    always_comb begin
        unique case (f_item_reg.src)
            SRC_INPUT: resolved = f_item_reg.in_chroma;
            SRC_LINE:  resolved = chroma_t'(ram_rdata);
            default:   resolved = held_chroma_reg;
        endcase
    end

    always_comb begin
        col_next         = col_reg;
        row_next         = row_reg;
        f_valid_next     = f_valid_reg;
        f_item_next      = f_item_reg;
        held_chroma_next = held_chroma_reg;
        if (move) begin
            held_chroma_next = resolved;
            f_valid_next     = 1'b0;
        end
        if (accept) begin
            f_valid_next          = 1'b1;
            f_item_next.luma      = s_data.luma;
            f_item_next.in_chroma = '{cr: s_data.cr_sample, cb: s_data.cb_sample};
            f_item_next.src       = src;
            f_item_next.line_end  = line_end;
            f_item_next.frame_end = frame_end;
            if (line_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            f_valid_reg     <= 1'b0;
            held_chroma_reg <= '0;
        end else begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            f_valid_reg     <= f_valid_next;
            held_chroma_reg <= held_chroma_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_item_reg <= f_item_next;
    end

    assign wk_valid          = f_valid_reg;
    assign wk_data.luma      = f_item_reg.luma;
    assign wk_data.chroma    = resolved;
    assign wk_data.line_end  = f_item_reg.line_end;
    assign wk_data.frame_end = f_item_reg.frame_end;

endmodule

@@ rtl/nv21_queue.sv @@
module nv21_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  nv21_pkg::work_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output nv21_pkg::work_t pop_data
);

    import nv21_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/nv21_back.sv @@
module nv21_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wk_valid,
    output logic               wk_ready,
    input  nv21_pkg::work_t    wk_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nv21_pkg::pix_out_t m_data
);

    import nv21_pkg::*;

    localparam int YY_W = 19;
    localparam int P_W  = 21;
    localparam int S_W  = 23;

    localparam logic [YY_W-1:0]       K_Y  = YY_W'(COEF_Y);
    localparam logic signed [P_W-1:0] K_RV = P_W'(COEF_RV);
    localparam logic signed [P_W-1:0] K_GV = P_W'(COEF_GV);
    localparam logic signed [P_W-1:0] K_GU = P_W'(COEF_GU);
    localparam logic signed [P_W-1:0] K_BU = P_W'(COEF_BU);

    typedef struct packed {
        logic [YY_W-1:0]       yy;
        logic signed [P_W-1:0] rv;
        logic signed [P_W-1:0] gv;
        logic signed [P_W-1:0] gu;
        logic signed [P_W-1:0] bu;
        logic                  line_end;
        logic                  frame_end;
    } prod_t;

    logic                  p_valid_reg, p_valid_next;
    prod_t                 p_reg, p_next;
    logic                  m_valid_reg, m_valid_next;
    pix_out_t              m_data_reg, m_data_next;
    logic                  out_free, p_load;

    logic [YY_W-1:0]       y_off;
    logic signed [P_W-1:0] v_ext, u_ext;
    logic signed [S_W-1:0] r_sum, g_sum, b_sum;
    logic [17:0]           r_clip, g_clip, b_clip;

    assign out_free = !m_valid_reg || m_ready;
    assign wk_ready = !p_valid_reg || out_free;
    assign p_load   = wk_valid && wk_ready;

    // Stage one: offsets and constant products
    always_comb begin
        y_off = (wk_data.luma > LUMA_OFFSET) ? YY_W'(wk_data.luma - LUMA_OFFSET) : '0;
        v_ext = $signed(P_W'({1'b0, wk_data.chroma.cr})) - $signed(P_W'(CHROMA_OFFSET));
        u_ext = $signed(P_W'({1'b0, wk_data.chroma.cb})) - $signed(P_W'(CHROMA_OFFSET));
        p_next           = p_reg;
        p_next.yy        = K_Y * y_off;
        p_next.rv        = K_RV * v_ext;
        p_next.gv        = K_GV * v_ext;
        p_next.gu        = K_GU * u_ext;
        p_next.bu        = K_BU * u_ext;
        p_next.line_end  = wk_data.line_end;
        p_next.frame_end = wk_data.frame_end;
    end

    function automatic logic [17:0] clip18(input logic signed [S_W-1:0] v);
        logic [17:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed(S_W'(CHAN_MAX))) begin
            res = CHAN_MAX;
        end else begin
            res = v[17:0];
        end
        return res;
    endfunction

    // Stage two: sums, clipping and packing
    always_comb begin
        r_sum  = $signed(S_W'(p_reg.yy)) + S_W'(p_reg.rv);
        g_sum  = $signed(S_W'(p_reg.yy)) - S_W'(p_reg.gv) - S_W'(p_reg.gu);
        b_sum  = $signed(S_W'(p_reg.yy)) + S_W'(p_reg.bu);
        r_clip = clip18(r_sum);
        g_clip = clip18(g_sum);
        b_clip = clip18(b_sum);
        m_data_next.argb_word = {ALPHA_OPAQUE, r_clip[17:10], g_clip[17:10], b_clip[17:10]};
        m_data_next.line_end  = p_reg.line_end;
        m_data_next.frame_end = p_reg.frame_end;
    end

    always_comb begin
        p_valid_next = wk_ready ? wk_valid : p_valid_reg;
        m_valid_next = out_free ? p_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_reg <= p_next;
        end
        if (out_free && p_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/nv21_to_rgba_converter_top.sv @@
// NV21 to ARGB converter. Takes one luma pixel per transfer in raster order, with the V/U
// pair carried alongside (sampled only on even rows at even columns), and returns one
// 0xffRRGGBB word per pixel with line and frame end flags. Throughput is one pixel per
// clock while m_ready does not stall the output. Each input transfer passes through the
// classify register (loaded at the transfer edge, and also waiting on the registered read
// of the chroma line store), the two-entry queue, the product register and the output
// register before output valid rises. Odd rows reuse chroma saved in a line
// store of MAX_WIDTH/2 entries; it needs no clearing, since every odd row reads only
// entries written by the even row before it. half_width and frame_height are clamped to
// 1..MAX_WIDTH/2 and 1..MAX_HEIGHT; write them only while the block is idle.
module nv21_to_rgba_converter_top #(
    parameter int MAX_WIDTH  = nv21_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nv21_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nv21_pkg::APB_AW-1:0]   paddr,
    input  logic [nv21_pkg::APB_DW-1:0]   pwdata,
    output logic [nv21_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  nv21_pkg::pix_in_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nv21_pkg::pix_out_t            m_data
);

    import nv21_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    cfg_reg_t reg_sel;
    logic     cfg_wr;

    logic     fq_valid, fq_ready;
    work_t    fq_data;
    logic     qb_valid, qb_ready;
    work_t    qb_data;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_HALF_WIDTH: begin
                prdata = APB_DW'(cfg_reg.half_width);
                if (cfg_wr) begin
                    cfg_next.half_width = pwdata[HALF_WIDTH_W-1:0];
                end
            end
            REG_FRAME_HEIGHT: begin
                prdata = APB_DW'(cfg_reg.frame_height);
                if (cfg_wr) begin
                    cfg_next.frame_height = pwdata[FRAME_HEIGHT_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_width   <= HALF_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nv21_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .wk_valid (fq_valid),
        .wk_ready (fq_ready),
        .wk_data  (fq_data)
    );

    nv21_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    nv21_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wk_valid (qb_valid),
        .wk_ready (qb_ready),
        .wk_data  (qb_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A full queue must stall the front end while it holds an item
    a_front_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid && !fq_ready |-> !s_ready)
        else $error("input taken while classified pixel is blocked");

    // A queued pixel waiting on the math pipeline stays queued
    a_queue_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        qb_valid && !qb_ready |=> qb_valid && $stable(qb_data))
        else $error("queued pixel lost while stalled");

    // Reset empties the pipeline and opens the input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready && !qb_valid)
        else $error("pipeline not empty after reset");

endmodule

@@ verif/nv21_to_rgba_converter_top_tb.sv @@
module nv21_to_rgba_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nv21_pkg::*;

    localparam int LINE_SLOTS  = MAX_WIDTH_DEF / 2;
    localparam int CYCLE_LIMIT = 150000;
    localparam int RANDOM_PIXELS = 260;

    // Tracks the converter state and holds the ARGB words still owed by the block.
    class nv21_argb_predictor;
        int unsigned errors;
        pix_out_t    expected_argb[$];
        logic [HALF_WIDTH_W-1:0]   half_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
        chroma_t     line_store[LINE_SLOTS];
        bit          slot_written[LINE_SLOTS];
        chroma_t     held;
        int unsigned col;
        int unsigned row;

        function new();
            errors = 0;
            half_width = HALF_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            held = '0;
            col = 0;
            row = 0;
            foreach (line_store[i]) begin
                line_store[i] = '0;
                slot_written[i] = 1'b0;
            end
        endfunction

        function int unsigned eff_half_width(logic [HALF_WIDTH_W-1:0] raw);
            if (raw < 1) return 1;
            if (raw > LINE_SLOTS) return LINE_SLOTS;
            return 32'(raw);
        endfunction

        function int unsigned eff_height(logic [FRAME_HEIGHT_W-1:0] raw);
            if (raw < 1) return 1;
            if (raw > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
            return 32'(raw);
        endfunction

        function int clip_chan(int x);
            if (x < 0) return 0;
            if (x > int'(CHAN_MAX)) return int'(CHAN_MAX);
            return x;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            if (idx == REG_HALF_WIDTH)
                half_width = val[HALF_WIDTH_W-1:0];
            else
                frame_height = val[FRAME_HEIGHT_W-1:0];
        endfunction

        // An odd row must never read a line store slot that no even row wrote.
        function bit hw_growth_safe(logic [31:0] val);
            int unsigned hw;
            hw = eff_half_width(val[HALF_WIDTH_W-1:0]);
            if (row % 2 == 0) return 1'b1;
            for (int s = 0; s < hw; s++)
                if (!slot_written[s]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_pixel(pix_in_t px);
            int unsigned last_col, last_row, slot;
            int y, yy, v, u, r, g, b;
            pix_out_t res;
            last_col = 2 * eff_half_width(half_width) - 1;
            last_row = eff_height(frame_height) - 1;
            slot = col >> 1;
            if (slot >= LINE_SLOTS) slot = LINE_SLOTS - 1;
            if (col % 2 == 0) begin
                if (row % 2 == 0) begin
                    held = {px.cr_sample, px.cb_sample};
                    line_store[slot] = held;
                    slot_written[slot] = 1'b1;
                end else begin
                    held = line_store[slot];
                end
            end
            y  = int'(px.luma) - int'(LUMA_OFFSET);
            yy = (y > 0) ? int'(COEF_Y) * y : 0;
            v  = int'(held.cr) - int'(CHROMA_OFFSET);
            u  = int'(held.cb) - int'(CHROMA_OFFSET);
            r = clip_chan(yy + int'(COEF_RV) * v);
            g = clip_chan(yy - int'(COEF_GV) * v - int'(COEF_GU) * u);
            b = clip_chan(yy + int'(COEF_BU) * u);
            res.argb_word = {ALPHA_OPAQUE, r[17:10], g[17:10], b[17:10]};
            res.line_end  = (col >= last_col);
            res.frame_end = res.line_end && (row >= last_row);
            if (res.line_end) begin
                col = 0;
                row = res.frame_end ? 0 : row + 1;
            end else begin
                col++;
            end
            expected_argb.push_back(res);
        endfunction

        function int pending();
            return expected_argb.size();
        endfunction

        task report(string msg);
            errors++;
            $display("%s", msg);
        endtask

        task check_argb(pix_out_t got);
            pix_out_t want;
            if (expected_argb.size() == 0) begin
                report($sformatf("unexpected pixel transfer: argb %h", got.argb_word));
                return;
            end
            want = expected_argb.pop_front();
            if (got.argb_word !== want.argb_word)
                report($sformatf("argb_word: got %h want %h", got.argb_word, want.argb_word));
            if (got.line_end !== want.line_end)
                report($sformatf("line_end: got %b want %b", got.line_end, want.line_end));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end: got %b want %b", got.frame_end, want.frame_end));
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pix_in_t             s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pix_out_t            m_data;

    nv21_argb_predictor argb_pred;
    int  send_calm = 0;
    int  recv_calm = 0;
    bit  sender_no_gaps = 1'b0;
    bit  hold_off_req = 1'b0;
    int  cycles = 0;

    nv21_to_rgba_converter_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("nv21_to_rgba_converter_top_tb: errors");
            $finish;
        end
    end

    // Random idle wait before a transfer, with occasional stretches of back-to-back transfers.
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 17));
            1: return 8'($urandom_range(238, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_HALF_WIDTH) ? 32'(val[HALF_WIDTH_W-1:0])
                                       : 32'(val[FRAME_HEIGHT_W-1:0]);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        argb_pred.set_reg(idx, val);
        // keep psel high and turn the bus around for a read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want)
            argb_pred.report($sformatf("read back of %s: got %h want %h",
                                       idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] hw, input logic [31:0] fh);
        logic [31:0] hw_val;
        hw_val = argb_pred.hw_growth_safe(hw) ? hw : 32'(argb_pred.half_width);
        write_reg(REG_HALF_WIDTH, hw_val);
        write_reg(REG_FRAME_HEIGHT, fh);
    endtask

    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cr,
                              input logic [7:0] cb);
        int gap;
        pix_in_t px;
        px.luma = luma;
        px.cr_sample = cr;
        px.cb_sample = cb;
        gap = sender_no_gaps ? 0 : draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        argb_pred.note_pixel(px);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(pick_sample(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every owed pixel has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (argb_pred.pending() != 0);
    endtask

    task automatic random_config();
        logic [31:0] hw, fh;
        int sel;
        hw = $urandom_range(1, 6);
        fh = $urandom_range(1, 6);
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: hw = 0;
                1: hw = LINE_SLOTS;
                2: hw = LINE_SLOTS + 1;
                default: hw = 2047;
            endcase
        end else if (sel == 1) begin
            case ($urandom_range(0, 3))
                0: fh = 0;
                1: fh = MAX_HEIGHT_DEF;
                2: fh = MAX_HEIGHT_DEF + 1;
                default: fh = 8191;
            endcase
        end else if (sel == 2) begin
            hw = hw | ($urandom << HALF_WIDTH_W);
            fh = fh | ($urandom << FRAME_HEIGHT_W);
        end
        set_geometry(hw, fh);
    endtask

    initial begin
        int gap;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = draw_gap(recv_calm);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = 80;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            argb_pred.check_argb(m_data);
        end
    end

    initial begin
        logic [7:0] lumas[20];
        logic [7:0] crs[5];
        logic [7:0] cbs[5];
        int random_sent;
        int n;
        argb_pred = new();
        lumas = '{0, 15, 16, 17, 255, 235, 128, 1, 255, 0,
                  16, 240, 100, 200, 50, 255, 16, 17, 254, 0};
        crs = '{0, 255, 128, 0, 255};
        cbs = '{0, 255, 128, 255, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // 2x2 frames: every pixel position of a chroma block, upper bits of writes masked
        set_geometry(32'hFFFF_F801, 32'hFFFF_E002);
        for (int i = 0; i < 20; i++) begin
            if (i % 4 == 0)
                send_pixel(lumas[i], crs[i / 4], cbs[i / 4]);
            else
                send_pixel(lumas[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        drain();

        // zero registers saturate to the smallest frame
        set_geometry(0, 0);
        send_random(8);
        drain();

        // widest lines, then shrink mid-line so the counter lands past the last column
        set_geometry(2047, 8191);
        send_random(30);
        drain();
        set_geometry(4, MAX_HEIGHT_DEF);
        send_random(10);
        drain();

        // receiver holds off while the sender keeps offering back to back
        set_geometry(3, 3);
        sender_no_gaps = 1'b1;
        hold_off_req = 1'b1;
        send_random(60);
        sender_no_gaps = 1'b0;
        drain();

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            random_config();
            n = $urandom_range(4, 50);
            send_random(n);
            random_sent += n;
            drain();
        end

        repeat (20) @(posedge aclk);
        if (argb_pred.errors == 0 && argb_pred.pending() == 0)
            $display("nv21_to_rgba_converter_top_tb: clean");
        else
            $display("nv21_to_rgba_converter_top_tb: errors");
        $finish;
    end

endmodule

@@ nv21_to_rgba_converter_top.f @@
rtl/nv21_pkg.sv
rtl/nv21_ram.sv
rtl/nv21_front.sv
rtl/nv21_queue.sv
rtl/nv21_back.sv
rtl/nv21_to_rgba_converter_top.sv
verif/nv21_to_rgba_converter_top_tb.sv
